// File: rtl/obla_pkg.sv
`timescale 1ns / 1ps
package obla_pkg;

  localparam int PRICE_W  = 10;
  localparam int IN_VOL_W = 16;
  localparam int VOL_W    = 32;
  localparam int SHOWN_W  = 6;

  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_REPORT = 1'b1;
  localparam logic SIDE_SELL = 1'b0;
  localparam logic SIDE_BUY  = 1'b1;

  typedef struct packed {
    logic                opcode;
    logic                side;
    logic [PRICE_W-1:0]  price;
    logic [IN_VOL_W-1:0] volume;
  } in_t;

  typedef struct packed {
    logic               out_side;
    logic [PRICE_W-1:0] out_price;
    logic [VOL_W-1:0]   out_volume;
    logic               last;
  } out_t;

  typedef struct packed {
    logic [PRICE_W-1:0] price;
    logic [VOL_W-1:0]   volume;
  } level_t;

endpackage

// File: rtl/obla_cell.sv
`timescale 1ns / 1ps
module obla_cell (
  input  logic            clk,
  input  logic            push,
  input  logic            pop,
  input  obla_pkg::level_t left_in,
  input  obla_pkg::level_t right_in,
  output obla_pkg::level_t q
);

  // A push moves every entry one cell away from the top; a pop moves it back.
  always_ff @(posedge clk) begin
    if (push) begin
      q <= left_in;
    end else if (pop) begin
      q <= right_in;
    end
  end

endmodule

// File: rtl/obla_ram.sv
`timescale 1ns / 1ps
module obla_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [obla_pkg::VOL_W-1:0] wdata,
  input  logic [AW-1:0]              raddr,
  output logic [obla_pkg::VOL_W-1:0] rdata
);

  logic [obla_pkg::VOL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/order_book_level_aggregator_unit.sv
`timescale 1ns / 1ps
// Order book level aggregator.
// Input channel (in_valid / in_stall / in_data): an add request sums its
// volume into the price level of its side, saturating at all ones; a
// report request emits the lowest shown sell levels (highest price first)
// and then up to the same number of buy levels from the highest price down.
// The final result of a report has last set; an empty report gives nothing.
// An add passes through accept, read and write; an add beyond the table
// is dropped at its accept. A report passes through its accept, a read
// and a check per price level scanned on each side plus one more read on
// a side that the shown limit ends early, one pop per sell level from the
// cell chain plus one step to leave the pops, and a final step. Results
// leave one at a time through the output register.
// After reset the block clears both tables, one price level per cycle,
// while in_stall stays high; shown resets to 32. The user must write it
// through cfg_wr_en / cfg_wr_data only while idle; the block does not enforce this.
// When out_stall holds the output register full, the report walk waits
// and resumes without losing or repeating a level.
module order_book_level_aggregator_unit #(
  parameter int PRICE_LEVELS = 1024,
  parameter int MAX_SHOWN    = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  obla_pkg::in_t                in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output obla_pkg::out_t               out_data,
  input  logic                         cfg_wr_en,
  input  logic [obla_pkg::SHOWN_W-1:0] cfg_wr_data
);

  localparam int AW = (PRICE_LEVELS > 1) ? $clog2(PRICE_LEVELS) : 1;
  localparam int CW = $clog2(MAX_SHOWN + 1);
  localparam logic [AW-1:0] MAX_ADDR = AW'(PRICE_LEVELS - 1);

  typedef enum logic [3:0] {
    CLEAR, IDLE, ADD_RD, ADD_WR, S_RD, S_CHK, S_POP, B_RD, B_CHK, FINISH
  } state_t;

  state_t                         state;
  logic [obla_pkg::SHOWN_W-1:0]   shown;
  logic [CW-1:0]                  limit;
  logic [CW-1:0]                  cnt;
  logic [AW-1:0]                  scan_addr;
  logic [AW-1:0]                  add_addr;
  logic                           add_side;
  logic [obla_pkg::IN_VOL_W-1:0]  add_vol;
  logic                           held_valid;
  obla_pkg::level_t               held;
  logic                           held_side;

  logic [AW-1:0]                  raddr;
  logic [obla_pkg::VOL_W-1:0]     sell_rdata, buy_rdata, rdata;
  logic                           sell_we, buy_we;
  logic [obla_pkg::VOL_W-1:0]     wdata;
  logic [obla_pkg::VOL_W:0]       sum;

  logic                           out_free, emit_new, can_emit, load_out;
  obla_pkg::level_t               new_level;
  logic                           new_side;
  logic                           push, pop;
  obla_pkg::level_t               chain [MAX_SHOWN];

  assign limit = (shown > obla_pkg::SHOWN_W'(MAX_SHOWN)) ? CW'(MAX_SHOWN) : CW'(shown);
  assign in_stall = (state != IDLE);
  assign out_free = !out_valid || !out_stall;

  assign raddr = (state == ADD_RD) ? add_addr : scan_addr;
  always_comb begin
    case (state) inside
      ADD_WR:       rdata = add_side ? buy_rdata : sell_rdata;
      B_RD, B_CHK:  rdata = buy_rdata;
      default:      rdata = sell_rdata;
    endcase
  end

  assign sum = {1'b0, rdata} + (obla_pkg::VOL_W + 1)'(add_vol);
  assign wdata = (state == CLEAR) ? '0 :
                 (sum[obla_pkg::VOL_W] ? '1 : sum[obla_pkg::VOL_W-1:0]);
  assign sell_we = (state == CLEAR) || (state == ADD_WR && add_side == obla_pkg::SIDE_SELL);
  assign buy_we  = (state == CLEAR) || (state == ADD_WR && add_side == obla_pkg::SIDE_BUY);

  obla_ram #(.DEPTH(PRICE_LEVELS), .AW(AW)) u_sell (
    .clk(clk), .we(sell_we), .waddr((state == CLEAR) ? scan_addr : add_addr),
    .wdata(wdata), .raddr(raddr), .rdata(sell_rdata)
  );

  obla_ram #(.DEPTH(PRICE_LEVELS), .AW(AW)) u_buy (
    .clk(clk), .we(buy_we), .waddr((state == CLEAR) ? scan_addr : add_addr),
    .wdata(wdata), .raddr(raddr), .rdata(buy_rdata)
  );

  // Found sell levels are stacked in the cell chain so they come out in
  // reverse order of the scan.
  assign push = (state == S_CHK) && (rdata != '0);
  assign pop  = (state == S_POP) && (cnt != '0) && can_emit;

  genvar gi;
  generate
    for (gi = 0; gi < MAX_SHOWN; gi++) begin : g_chain
      obla_pkg::level_t left_in, right_in;
      if (gi == 0) begin : g_first
        assign left_in = '{price: obla_pkg::PRICE_W'(scan_addr), volume: rdata};
      end else begin : g_mid
        assign left_in = chain[gi-1];
      end
      if (gi == MAX_SHOWN - 1) begin : g_end
        assign right_in = '0;
      end else begin : g_inner
        assign right_in = chain[gi+1];
      end
      obla_cell u_cell (
        .clk(clk), .push(push), .pop(pop),
        .left_in(left_in), .right_in(right_in), .q(chain[gi])
      );
    end
  endgenerate

  // A new level enters the hold register; the held one is only sent once
  // the next level arrives, or at FINISH with last set.
  always_comb begin
    emit_new  = 1'b0;
    new_level = chain[0];
    new_side  = obla_pkg::SIDE_SELL;
    if (state == S_POP && cnt != '0) begin
      emit_new = 1'b1;
    end else if (state == B_CHK && rdata != '0) begin
      emit_new  = 1'b1;
      new_level = '{price: obla_pkg::PRICE_W'(scan_addr), volume: rdata};
      new_side  = obla_pkg::SIDE_BUY;
    end
  end
  assign can_emit = !held_valid || out_free;
  assign load_out = held_valid && out_free &&
                    ((emit_new) || (state == FINISH));

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= CLEAR;
      scan_addr  <= '0;
      cnt        <= '0;
      shown      <= obla_pkg::SHOWN_W'(32);
      held_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        shown <= cfg_wr_data;
      end
      if (load_out) begin
        out_valid           <= 1'b1;
        out_data.out_side   <= held_side;
        out_data.out_price  <= held.price;
        out_data.out_volume <= held.volume;
        out_data.last       <= (state == FINISH);
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (emit_new && can_emit) begin
        held_valid <= 1'b1;
        held       <= new_level;
        held_side  <= new_side;
      end else if (state == FINISH && load_out) begin
        held_valid <= 1'b0;
      end

      unique case (state)
        CLEAR: begin
          if (scan_addr == MAX_ADDR) begin
            state <= IDLE;
          end else begin
            scan_addr <= scan_addr + AW'(1);
          end
        end
        IDLE: begin
          if (in_valid) begin
            add_side <= in_data.side;
            add_addr <= AW'(in_data.price);
            add_vol  <= in_data.volume;
            scan_addr <= '0;
            cnt       <= '0;
            if (in_data.opcode == obla_pkg::OP_REPORT) begin
              state <= S_RD;
            end else if (17'(in_data.price) < 17'(PRICE_LEVELS)) begin
              state <= ADD_RD;
            end
          end
        end
        ADD_RD: state <= ADD_WR;
        ADD_WR: state <= IDLE;
        S_RD: begin
          state <= (cnt == limit) ? S_POP : S_CHK;
        end
        S_CHK: begin
          if (push) begin
            cnt <= cnt + CW'(1);
          end
          if (scan_addr == MAX_ADDR) begin
            state <= S_POP;
          end else begin
            scan_addr <= scan_addr + AW'(1);
            state     <= S_RD;
          end
        end
        S_POP: begin
          if (cnt == '0) begin
            scan_addr <= MAX_ADDR;
            state     <= B_RD;
          end else if (can_emit) begin
            cnt <= cnt - CW'(1);
          end
        end
        B_RD: begin
          state <= (cnt == limit) ? FINISH : B_CHK;
        end
        B_CHK: begin
          if (!emit_new || can_emit) begin
            if (emit_new) begin
              cnt <= cnt + CW'(1);
            end
            if (scan_addr == '0) begin
              state <= FINISH;
            end else begin
              scan_addr <= scan_addr - AW'(1);
              state     <= B_RD;
            end
          end
        end
        FINISH: begin
          if (!held_valid || out_free) begin
            state <= IDLE;
          end
        end
        default: state <= CLEAR;
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(MAX_SHOWN))
    else $error("level count beyond chain length");

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    state == IDLE |-> !held_valid)
    else $error("held level left over after a report");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    load_out |-> out_free)
    else $error("output register overwritten while stalled");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push |-> cnt < limit)
    else $error("sell level pushed beyond the shown limit");

endmodule
